### rtl/spq_pkg.sv
// package for the sorted priority queue: types, codes and input clamps
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int TIME_W = 5;
    localparam int PRI_W  = 3;

    localparam logic [TIME_W-1:0] TIME_MAX = 5'd30;
    localparam logic [TIME_W-1:0] TIME_MIN = 5'd1;
    localparam logic [PRI_W-1:0]  PRI_MAX  = 3'd4;
    localparam logic [PRI_W-1:0]  PRI_MIN  = 3'd1;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_REMOVED  = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] service;
        logic [PRI_W-1:0]  prio;
    } entry_t;

    typedef struct packed {
        logic   ins_en;
        logic   rem_en;
        entry_t new_entry;
    } cell_ctl_t;

    function automatic logic [TIME_W-1:0] clamp_time(input logic [5:0] v);
        logic [TIME_W-1:0] r;
        if (v < 6'(TIME_MIN) || v > 6'(TIME_MAX)) begin
            r = TIME_MAX;
        end else begin
            r = v[TIME_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [PRI_W-1:0] clamp_pri(input logic [2:0] v);
        logic [PRI_W-1:0] r;
        if (v < PRI_MIN || v > PRI_MAX) begin
            r = PRI_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/sorted_priority_queue.sv
// top level of the sorted priority queue: cell row, count and result register
//
// Bounded priority queue of records (arrival, service, priority).
// Input channel s_*: s_cmd selects insert or remove of the head record;
// arrival, service and priority are clamped on insert. Lower priority
// leaves first; equal priority leaves by arrival, then in insert order.
// Result channel m_*: one item per input item, with m_status inserted,
// removed, empty or full, and the head record's fields on a remove
// (zero otherwise).
// The result is registered and valid in the cycle after the input is accepted.
// Throughput: one item per cycle while results are taken; every cell of
// the row compares against the new record and shifts in the same cycle,
// so no item waits on another. The input is taken while the result register
// is empty or is being read in the same cycle; when the receiver stalls, one
// result waits and s_ready drops until it is taken.
// Reset (aresetn low, synchronous) empties the queue and drops m_valid;
// the cell contents are not cleared, the fill count marks what is valid.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_cmd,
    input  wire logic [5:0]  s_arrival_in,
    input  wire logic [5:0]  s_service_in,
    input  wire logic [2:0]  s_priority_in,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [4:0]       m_arrival_out,
    output logic [4:0]       m_service_out,
    output logic [2:0]       m_priority_out
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               m_valid_reg;
    logic               m_valid_next;
    logic [1:0]         status_reg;
    logic [1:0]         status_next;
    spq_pkg::entry_t    out_reg;
    spq_pkg::entry_t    out_next;

    spq_pkg::cell_ctl_t ctl;
    spq_pkg::entry_t    cell_entry [CAPACITY];
    logic               cell_ahead [CAPACITY];

    logic accept;
    logic full;
    logic empty;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign empty   = (count_reg == '0);

    always_comb begin
        ctl.ins_en            = accept && (s_cmd == spq_pkg::CMD_INSERT) && !full;
        ctl.rem_en            = accept && (s_cmd == spq_pkg::CMD_REMOVE) && !empty;
        ctl.new_entry.arrival = spq_pkg::clamp_time(s_arrival_in);
        ctl.new_entry.service = spq_pkg::clamp_time(s_service_in);
        ctl.new_entry.prio    = spq_pkg::clamp_pri(s_priority_in);
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        spq_pkg::entry_t left_e;
        spq_pkg::entry_t right_e;
        logic            left_a;
        logic            occ;

        assign occ = (count_reg > CNT_W'(i));

        if (i == 0) begin : g_first
            assign left_e = ctl.new_entry;
            assign left_a = 1'b1;
        end else begin : g_mid
            assign left_e = cell_entry[i-1];
            assign left_a = cell_ahead[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_e = cell_entry[i];
        end else begin : g_inner
            assign right_e = cell_entry[i+1];
        end

        spq_cell u_cell (
            .aclk        (aclk),
            .ctl         (ctl),
            .occ         (occ),
            .left_entry  (left_e),
            .left_ahead  (left_a),
            .right_entry (right_e),
            .entry       (cell_entry[i]),
            .ahead       (cell_ahead[i])
        );
    end

    always_comb begin
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        status_next  = status_reg;
        out_next     = out_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            m_valid_next = 1'b1;
            out_next     = '0;
            if (s_cmd == spq_pkg::CMD_INSERT) begin
                if (full) begin
                    status_next = spq_pkg::ST_FULL;
                end else begin
                    status_next = spq_pkg::ST_INSERTED;
                    count_next  = count_reg + CNT_W'(1);
                end
            end else begin
                if (empty) begin
                    status_next = spq_pkg::ST_EMPTY;
                end else begin
                    status_next = spq_pkg::ST_REMOVED;
                    out_next    = cell_entry[0];
                    count_next  = count_reg - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        out_reg    <= out_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_arrival_out  = out_reg.arrival;
    assign m_service_out  = out_reg.service;
    assign m_priority_out = out_reg.prio;

endmodule

`default_nettype wire

### rtl/spq_cell.sv
// one cell of the sorted shift row: holds an entry, shifts on insert and remove
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
    input  wire logic               aclk,
    input  wire spq_pkg::cell_ctl_t ctl,
    input  wire logic               occ,
    input  wire spq_pkg::entry_t    left_entry,
    input  wire logic               left_ahead,
    input  wire spq_pkg::entry_t    right_entry,
    output spq_pkg::entry_t         entry,
    output logic                    ahead
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;

    // stored entry leaves before the new one
    always_comb begin
        ahead = occ && ((entry_reg.prio < ctl.new_entry.prio) ||
                        ((entry_reg.prio == ctl.new_entry.prio) &&
                         (entry_reg.arrival <= ctl.new_entry.arrival)));
    end

    always_comb begin
        entry_next = entry_reg;
        if (ctl.ins_en) begin
            if (!ahead) begin
                entry_next = left_ahead ? ctl.new_entry : left_entry;
            end
        end else if (ctl.rem_en) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

### rtl/spq_checker.sv
// port checker for the sorted priority queue, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module spq_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [1:0] m_status,
    input wire logic [4:0] m_arrival_out,
    input wire logic [4:0] m_service_out,
    input wire logic [2:0] m_priority_out
);

    // no result right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) &&
            $stable(m_arrival_out) && $stable(m_service_out) && $stable(m_priority_out))
        else $error("stalled result changed");

    // only a removed item carries a record
    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != spq_pkg::ST_REMOVED) |->
            (m_arrival_out == '0) && (m_service_out == '0) && (m_priority_out == '0))
        else $error("nonzero fields without a removed record");

    // removed record is within the clamped ranges
    a_removed_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == spq_pkg::ST_REMOVED) |->
            (m_priority_out >= spq_pkg::PRI_MIN) && (m_priority_out <= spq_pkg::PRI_MAX) &&
            (m_arrival_out >= spq_pkg::TIME_MIN) && (m_arrival_out <= spq_pkg::TIME_MAX) &&
            (m_service_out >= spq_pkg::TIME_MIN) && (m_service_out <= spq_pkg::TIME_MAX))
        else $error("removed record out of range");

    // input side is free whenever no result waits
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with no result pending");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_arrival_out  (m_arrival_out),
    .m_service_out  (m_service_out),
    .m_priority_out (m_priority_out)
);

`default_nettype wire
